>>> hdl/note_text_to_tone_parser_core_defines.svh
// ----------------------------------------------------------------------------
// Note text to tone parser - assertion macros
// Shared concurrent assertion helpers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NOTE_TEXT_TO_TONE_PARSER_CORE_DEFINES_SVH
`define NOTE_TEXT_TO_TONE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication.
`define NTP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define NTP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/ntp_pkg.sv
// ----------------------------------------------------------------------------
// ntp_pkg
// Types, constants and decode helpers for the note text to tone parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ntp_pkg;

	// Command queue depth between parser and lookup stage
	localparam int CMD_DEPTH = 4;

	localparam int NOTE_COUNT = 17;

	// Reset values
	localparam logic [15:0] WHOLE_TICKS_RST = 16'd20;
	localparam logic [3:0]  OCTAVE_RST      = 4'd4;
	localparam logic [15:0] NOTE_CODE_RST   = 16'h4100;
	localparam logic [15:0] DUR_TICKS_RST   = 16'd10;
	localparam logic [15:0] DIVISOR_RST     = 16'd0;

	// Character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SHARP = 8'h23;
	localparam logic [7:0] CH_FLAT  = 8'h62;

	// Duration shift code for a non-duration letter
	localparam logic [2:0] DUR_NONE = 3'd6;

	typedef enum logic [1:0] {
		PH_OCTAVE   = 2'd0,
		PH_DURATION = 2'd1,
		PH_LETTER   = 2'd2,
		PH_MODIFIER = 2'd3
	} phase_t;

	// One finished note word handed from parser to lookup stage
	typedef struct packed {
		logic [15:0] note_code;
		logic [3:0]  octave;
		logic [15:0] ticks;
	} cmd_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	localparam logic [15:0] NOTE_KEYS [NOTE_COUNT] = '{
		16'h4100, 16'h4123, 16'h4262, 16'h4200, 16'h4300, 16'h4323,
		16'h4462, 16'h4400, 16'h4423, 16'h4562, 16'h4500, 16'h4600,
		16'h4623, 16'h4762, 16'h4700, 16'h4723, 16'h4162
	};

	localparam logic [15:0] NOTE_DIVS [NOTE_COUNT] = '{
		16'd61856, 16'd58384, 16'd58384, 16'd55107, 16'd52014, 16'd49095,
		16'd49095, 16'd46340, 16'd43739, 16'd43739, 16'd41284, 16'd38966,
		16'd36779, 16'd36779, 16'd34715, 16'd32767, 16'd32767
	};

	function automatic logic is_space(input logic [7:0] c);
		return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] c);
		if (c inside {[8'h61:8'h7A]}) begin
			return c - 8'h20;
		end
		return c;
	endfunction

	// Duration letter to right-shift amount, DUR_NONE when not a duration
	function automatic logic [2:0] dur_shift(input logic [7:0] c);
		logic [2:0] sh;
		sh = DUR_NONE;
		case (upcase(c))
			8'h57: sh = 3'd0;  // W
			8'h48: sh = 3'd1;  // H
			8'h51: sh = 3'd2;  // Q
			8'h45: sh = 3'd3;  // E
			8'h53: sh = 3'd4;  // S
			8'h54: sh = 3'd5;  // T
			default: sh = DUR_NONE;
		endcase
		return sh;
	endfunction

endpackage

`default_nettype wire

>>> hdl/note_text_to_tone_parser_core.sv
// A word-ending whitespace transfer is queued at the accepting edge, then looked up
// into the output register once that register is free or being popped.
// Throughput: one text byte per cycle; one lookup result per cycle while pop is held.
// Input stalls only when the command queue (CMD_DEPTH entries) is full.
// Reset (arst_n low, asynchronous): phase octave, octave 4, note 'A', duration 10,
// whole note 20, divisor 0, queue and result register empty.
// ----------------------------------------------------------------------------
// note_text_to_tone_parser_core
// Top level: byte parser front end, command queue and table lookup back end.
// ----------------------------------------------------------------------------
`default_nettype none

module note_text_to_tone_parser_core #(
	parameter int CMD_DEPTH = ntp_pkg::CMD_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  text_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [15:0]      tone_divisor,
	output logic [15:0]      tone_ticks,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	ntp_pkg::cmd_t      push_cmd;
	ntp_pkg::cmd_t      head_cmd;
	ntp_pkg::q_status_t q_status;
	logic               cmd_push;
	logic               cmd_pop;
	logic               byte_fire;

	assign full      = q_status.full;
	assign byte_fire = push && !full;
	assign cfg_ready = 1'b1;

	ntp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_fire (byte_fire),
		.text_byte (text_byte),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.cmd_push  (cmd_push),
		.cmd_data  (push_cmd)
	);

	ntp_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (push_cmd),
		.rd_en   (cmd_pop),
		.rd_data (head_cmd),
		.status  (q_status)
	);

	ntp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_data     (head_cmd),
		.q_status     (q_status),
		.cmd_pop      (cmd_pop),
		.pop          (pop),
		.empty        (empty),
		.tone_divisor (tone_divisor),
		.tone_ticks   (tone_ticks)
	);

endmodule

`default_nettype wire

>>> hdl/ntp_fifo.sv
// ----------------------------------------------------------------------------
// ntp_fifo
// Small register queue carrying note commands from parser to lookup stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ntp_fifo #(
	parameter int DEPTH = ntp_pkg::CMD_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire ntp_pkg::cmd_t     wr_data,
	input  wire logic              rd_en,
	output ntp_pkg::cmd_t          rd_data,
	output ntp_pkg::q_status_t     status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULLC = CW'(DEPTH);

	ntp_pkg::cmd_t    mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign status.full  = (count_q == FULLC);
	assign status.empty = (count_q == '0);
	assign do_wr = wr_en && !status.full;
	assign do_rd = rd_en && !status.empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/ntp_front.sv
// ----------------------------------------------------------------------------
// ntp_front
// Byte parser: tracks word phase, octave, duration and note name, and queues
// one command per word-ending whitespace.
// ----------------------------------------------------------------------------
`default_nettype none

module ntp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_fire,
	input  wire logic [7:0]        text_byte,
	input  wire logic              cfg_we,
	input  wire logic [15:0]       cfg_data,
	output logic                   cmd_push,
	output ntp_pkg::cmd_t          cmd_data
);

	ntp_pkg::phase_t phase_q;
	ntp_pkg::phase_t phase_d;
	logic [15:0]     whole_ticks_q;
	logic [3:0]      octave_q;
	logic [15:0]     note_code_q;
	logic [15:0]     dur_ticks_q;
	logic            byte_space;
	logic [2:0]      dur_sh;

	assign byte_space = ntp_pkg::is_space(text_byte);
	assign dur_sh     = ntp_pkg::dur_shift(text_byte);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (byte_fire) begin
			if (byte_space) begin
				phase_d = ntp_pkg::PH_OCTAVE;
			end else begin
				case (phase_q)
					ntp_pkg::PH_OCTAVE:   phase_d = ntp_pkg::PH_DURATION;
					ntp_pkg::PH_DURATION: phase_d = ntp_pkg::PH_LETTER;
					ntp_pkg::PH_LETTER:   phase_d = ntp_pkg::PH_MODIFIER;
					ntp_pkg::PH_MODIFIER: phase_d = ntp_pkg::PH_MODIFIER;
					default:              phase_d = ntp_pkg::PH_OCTAVE;
				endcase
			end
		end
	end

	// Command issue: whitespace after a non-empty word
	always_comb begin
		cmd_push = byte_fire && byte_space && (phase_q != ntp_pkg::PH_OCTAVE);
		cmd_data.note_code = note_code_q;
		cmd_data.octave    = octave_q;
		cmd_data.ticks     = dur_ticks_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= ntp_pkg::PH_OCTAVE;
			whole_ticks_q <= ntp_pkg::WHOLE_TICKS_RST;
			octave_q      <= ntp_pkg::OCTAVE_RST;
			note_code_q   <= ntp_pkg::NOTE_CODE_RST;
			dur_ticks_q   <= ntp_pkg::DUR_TICKS_RST;
		end else begin
			phase_q <= phase_d;
			if (cfg_we) begin
				whole_ticks_q <= cfg_data;
			end
			// Word field capture
			if (byte_fire && !byte_space) begin
				case (phase_q)
					ntp_pkg::PH_OCTAVE: begin
						octave_q <= 4'(text_byte - ntp_pkg::CH_ZERO);
					end
					ntp_pkg::PH_DURATION: begin
						if (dur_sh != ntp_pkg::DUR_NONE) begin
							dur_ticks_q <= whole_ticks_q >> dur_sh;
						end
					end
					ntp_pkg::PH_LETTER: begin
						note_code_q <= {ntp_pkg::upcase(text_byte), 8'h00};
					end
					ntp_pkg::PH_MODIFIER: begin
						if (text_byte == ntp_pkg::CH_SHARP || text_byte == ntp_pkg::CH_FLAT) begin
							note_code_q <= note_code_q | {8'h00, text_byte};
						end
					end
					default: begin
						note_code_q <= note_code_q;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/ntp_back.sv
// ----------------------------------------------------------------------------
// ntp_back
// Note table lookup, divisor hold and result output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "note_text_to_tone_parser_core_defines.svh"

module ntp_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ntp_pkg::cmd_t     cmd_data,
	input  wire ntp_pkg::q_status_t q_status,
	output logic                   cmd_pop,
	input  wire logic              pop,
	output logic                   empty,
	output logic [15:0]            tone_divisor,
	output logic [15:0]            tone_ticks
);

	logic        out_valid_q;
	logic [15:0] out_div_q;
	logic [15:0] out_ticks_q;
	logic [15:0] divisor_q;
	logic        hit;
	logic [15:0] hit_div;

	// Parallel compare against the note table
	always_comb begin
		hit     = 1'b0;
		hit_div = '0;
		for (int i = ntp_pkg::NOTE_COUNT - 1; i >= 0; i--) begin
			if (cmd_data.note_code == ntp_pkg::NOTE_KEYS[i]) begin
				hit     = 1'b1;
				hit_div = ntp_pkg::NOTE_DIVS[i] >> cmd_data.octave;
			end
		end
	end

	// Take a command whenever the output slot is free or draining
	assign cmd_pop      = !q_status.empty && (!out_valid_q || pop);
	assign empty        = !out_valid_q;
	assign tone_divisor = out_div_q;
	assign tone_ticks   = out_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			divisor_q   <= ntp_pkg::DIVISOR_RST;
		end else begin
			if (cmd_pop) begin
				out_valid_q <= 1'b1;
				if (hit) begin
					divisor_q <= hit_div;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			out_div_q   <= hit ? hit_div : divisor_q;
			out_ticks_q <= cmd_data.ticks;
		end
	end

	`NTP_ASSERT_IMPL(a_pop_needs_slot, cmd_pop, !out_valid_q || pop, "command taken while result slot busy")
	`NTP_ASSERT_IMPL(a_no_idle_slot, !q_status.empty && !out_valid_q, cmd_pop, "queued command left waiting with free slot")
	`NTP_ASSERT_NEXT(a_result_from_cmd, cmd_pop, out_valid_q && out_ticks_q == $past(cmd_data.ticks), "result does not follow taken command")
	`NTP_ASSERT_NEXT(a_divisor_kept, cmd_pop && !hit, divisor_q == $past(divisor_q), "divisor changed on table miss")

endmodule

`default_nettype wire

>>> tb/note_text_to_tone_parser_core_tb.sv
// ----------------------------------------------------------------------------
// note_text_to_tone_parser_core_tb
// Feeds note text byte by byte through the push/full queue port and checks
// every divisor/tick pair popped from the result side against an in-bench
// parser model. Covers reset values, every whitespace kind, duration letters
// in both cases, sharps and flats, table misses, truncated words, whole-note
// register extremes, random idling on both sides and a long result stall.
// ----------------------------------------------------------------------------
module note_text_to_tone_parser_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles with no transfer at all before the run is declared hung.
	// The longest legal gap is the counted result hold plus the quiet wait.
	localparam int STALL_LIMIT  = 3000;
	// Cycles to let the lookup stage settle before a register write.
	localparam int QUIET_CYCLES = 8;
	localparam int HOLD_CYCLES  = 400;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef struct packed {
		logic [15:0] divisor;
		logic [15:0] ticks;
	} tone_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [7:0]  text_byte = 8'h00;
	logic        pop = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [15:0] cfg_data = 16'h0000;
	logic        full;
	logic        empty;
	logic        cfg_ready;
	logic [15:0] tone_divisor;
	logic [15:0] tone_ticks;

	// Parser model state, starting at the reset values
	ntp_pkg::phase_t parse_at = ntp_pkg::PH_OCTAVE;
	logic [3:0]  octave       = 4'd4;
	logic [15:0] note_code    = 16'h4100;
	logic [15:0] dur_ticks    = 16'd10;
	logic [15:0] held_divisor = 16'd0;
	logic [15:0] whole_ticks  = 16'd20;

	tone_result_t tones_due[$];
	int mismatches = 0;
	int bytes_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;

	string dur_letters  = "whqestWHQEST";
	string note_letters = "ABCDEFGabcdefg";

	note_text_to_tone_parser_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.text_byte    (text_byte),
		.empty        (empty),
		.pop          (pop),
		.tone_divisor (tone_divisor),
		.tone_ticks   (tone_ticks),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic is_blank(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_LF ||
			b == CH_VT || b == CH_FF || b == CH_CR;
	endfunction

	// Chromatic table: {hit, base divisor} for a two-byte note name
	function automatic logic [16:0] pitch_lookup(input logic [15:0] code);
		case (code)
			16'h4100: return {1'b1, 16'd61856};
			16'h4123: return {1'b1, 16'd58384};
			16'h4262: return {1'b1, 16'd58384};
			16'h4200: return {1'b1, 16'd55107};
			16'h4300: return {1'b1, 16'd52014};
			16'h4323: return {1'b1, 16'd49095};
			16'h4462: return {1'b1, 16'd49095};
			16'h4400: return {1'b1, 16'd46340};
			16'h4423: return {1'b1, 16'd43739};
			16'h4562: return {1'b1, 16'd43739};
			16'h4500: return {1'b1, 16'd41284};
			16'h4600: return {1'b1, 16'd38966};
			16'h4623: return {1'b1, 16'd36779};
			16'h4762: return {1'b1, 16'd36779};
			16'h4700: return {1'b1, 16'd34715};
			16'h4723: return {1'b1, 16'd32767};
			16'h4162: return {1'b1, 16'd32767};
			default:  return 17'd0;
		endcase
	endfunction

	// Advance the parser model by one accepted byte; queue a tone on word end
	task automatic parse_text_byte(input logic [7:0] b);
		logic [7:0]   up;
		logic [7:0]   rel;
		logic [16:0]  hit;
		tone_result_t tone;
		up = (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
		if (is_blank(b)) begin
			if (parse_at != ntp_pkg::PH_OCTAVE) begin
				hit = pitch_lookup(note_code);
				if (hit[16])
					held_divisor = hit[15:0] >> octave;
				tone.divisor = held_divisor;
				tone.ticks = dur_ticks;
				tones_due.push_back(tone);
			end
			parse_at = ntp_pkg::PH_OCTAVE;
		end else begin
			case (parse_at)
				ntp_pkg::PH_OCTAVE: begin
					rel = b - ntp_pkg::CH_ZERO;
					octave = rel[3:0];
					parse_at = ntp_pkg::PH_DURATION;
				end
				ntp_pkg::PH_DURATION: begin
					case (up)
						"W": dur_ticks = whole_ticks;
						"H": dur_ticks = whole_ticks >> 1;
						"Q": dur_ticks = whole_ticks >> 2;
						"E": dur_ticks = whole_ticks >> 3;
						"S": dur_ticks = whole_ticks >> 4;
						"T": dur_ticks = whole_ticks >> 5;
						default: ;
					endcase
					parse_at = ntp_pkg::PH_LETTER;
				end
				ntp_pkg::PH_LETTER: begin
					note_code = {up, 8'h00};
					parse_at = ntp_pkg::PH_MODIFIER;
				end
				default: begin
					// sharp and flat accumulate, anything else is skipped
					if (b == ntp_pkg::CH_SHARP || b == ntp_pkg::CH_FLAT)
						note_code[7:0] = note_code[7:0] | b;
				end
			endcase
		end
	endtask

	task automatic note_mismatch(input string what, input logic [15:0] want,
			input logic [15:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("ERROR at %0t: %s expected %0d got %0d", $time, what, want, got);
	endtask

	// One byte transfer; push stays up so back-to-back bytes need no gap
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		text_byte <= b;
		do
			@(posedge clk);
		while (full);
		parse_text_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic logic [7:0] random_blank();
		case ($urandom_range(5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			3: return CH_VT;
			4: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] random_non_blank();
		logic [7:0] b;
		do
			b = $urandom_range(255);
		while (is_blank(b));
		return b;
	endfunction

	// Mostly well-formed note words; with noise, stray blanks and cut words
	task automatic send_random_word(input bit with_noise);
		int kind;
		kind = with_noise ? $urandom_range(99) : 99;
		if (kind < 5) begin
			send_byte(random_blank());
		end else if (kind < 12) begin
			repeat ($urandom_range(1, 2))
				send_byte(random_non_blank());
			send_byte(random_blank());
		end else begin
			if ($urandom_range(99) < 90)
				send_byte(ntp_pkg::CH_ZERO + 8'($urandom_range(9)));
			else
				send_byte(random_non_blank());
			if ($urandom_range(99) < 85)
				send_byte(dur_letters[$urandom_range(dur_letters.len() - 1)]);
			else
				send_byte(random_non_blank());
			if ($urandom_range(99) < 80)
				send_byte(note_letters[$urandom_range(note_letters.len() - 1)]);
			else
				send_byte(random_non_blank());
			repeat ($urandom_range(2)) begin
				if ($urandom_range(99) < 85)
					send_byte($urandom_range(1) ? ntp_pkg::CH_SHARP : ntp_pkg::CH_FLAT);
				else
					send_byte(random_non_blank());
			end
			send_byte(random_blank());
		end
	endtask

	// Drop push, wait for every pending tone, then let the back end settle
	task automatic wait_for_quiet();
		@(negedge clk);
		push <= 1'b0;
		while (tones_due.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_whole_note_ticks(input logic [15:0] value);
		wait_for_quiet();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		whole_ticks = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reset values: blank with no word, then a word with an unknown duration
	// letter and an unknown note keeps the reset duration and divisor
	task automatic test_reset_state();
		send_byte(CH_SPACE);
		send_text("4xZ\t");
	endtask

	// Blank kinds, case folding, sharp and flat stacking, wrapped octave,
	// table miss and an octave byte of all ones
	task automatic test_directed_words();
		send_text("0wA");
		send_byte(CH_CR);
		send_text("fsg#b\n");
		send_byte(8'hFF);
		send_text("xb");
		send_byte(CH_VT);
		send_text("2E");
		send_byte(8'h00);
		send_byte("b");
		send_byte(CH_FF);
	endtask

	task automatic test_whole_note_extremes();
		write_whole_note_ticks(16'h0000);
		send_text("3qC 9Wd ");
		write_whole_note_ticks(16'hFFFF);
		send_text("1Wc# 8Tg ");
	endtask

	task automatic test_random_text(input int n_bytes, input int send_pct,
			input int recv_pct, input logic [15:0] ticks);
		int start;
		write_whole_note_ticks(ticks);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes)
			send_random_word(1'b1);
	endtask

	// Result side holds off while words keep coming, so the queue fills
	task automatic test_result_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = HOLD_CYCLES;
		repeat (30) send_random_word(1'b0);
	endtask

	// Result side: random pop, or a counted hold when one is requested
	always @(negedge clk) begin : result_side
		static int hold_left = 0;
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Score each result transfer against the oldest pending tone
	always @(posedge clk) begin : score_results
		tone_result_t want;
		if (arst_n && pop && !empty) begin
			if (tones_due.size() == 0) begin
				note_mismatch("unexpected result, divisor", 16'h0000, tone_divisor);
			end else begin
				want = tones_due.pop_front();
				if (tone_divisor !== want.divisor)
					note_mismatch("tone_divisor", want.divisor, tone_divisor);
				if (tone_ticks !== want.ticks)
					note_mismatch("tone_ticks", want.ticks, tone_ticks);
			end
		end
	end

	// Hang detection: any transfer on any port restarts the count
	initial begin : watchdog
		int stalled;
		stalled = 0;
		@(posedge arst_n);
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("FAIL note_text_to_tone_parser_core");
		$finish;
	end

	initial begin : run_tests
		send_idle_pct = 25;
		recv_idle_pct = 70;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_directed_words();
		test_whole_note_extremes();
		test_random_text(200, 25, 70, 16'($urandom_range(65535)));
		test_random_text(200, 70, 25, 16'd1);
		test_random_text(200, 0, 0, 16'($urandom_range(65535)));
		test_result_backpressure();

		wait_for_quiet();
		if (mismatches == 0 && tones_due.size() == 0)
			$display("PASS note_text_to_tone_parser_core");
		else
			$display("FAIL note_text_to_tone_parser_core");
		$finish;
	end

endmodule
